/* src/jrs_pkg.sv */
// Package for the JPEG run/size encoder core.
// Holds word types, sizing constants and symbol codes; no dependencies.
package jrs_pkg;

  localparam int COEF_BITS   = 12;
  localparam int BLOCK_SIZE  = 64;
  localparam int POS_W       = 6;
  localparam int SIZE_W      = 4;
  localparam int SYM_W       = 8;
  localparam int ZRL_CNT_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [SYM_W-1:0] SYM_ZRL = 8'hF0;
  localparam logic [SYM_W-1:0] SYM_EOB = 8'h00;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(BLOCK_SIZE - 1);

  typedef struct packed {
    logic signed [COEF_BITS-1:0] coefficient;
    logic                        block_last;
  } in_word_t;

  typedef struct packed {
    logic [SYM_W-1:0]            run_size;
    logic signed [COEF_BITS-1:0] amplitude;
    logic                        result_last;
    logic                        block_done;
  } out_word_t;

  // one queued job: leading ZRL count plus the closing symbol
  typedef struct packed {
    logic [ZRL_CNT_W-1:0]        zrl;
    logic [SYM_W-1:0]            run_size;
    logic signed [COEF_BITS-1:0] amplitude;
    logic                        block_done;
  } job_t;

endpackage

/* src/jrs_front.sv */
// Front end: accepts coefficient words, tracks run and position, builds jobs.
// Depends on jrs_pkg.
module jrs_front #(
  parameter int BLOCK_SIZE = jrs_pkg::BLOCK_SIZE
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  jrs_pkg::in_word_t in_data,
  input  logic             q_full,
  output logic             push,
  output jrs_pkg::job_t    push_job
);

  localparam logic [jrs_pkg::POS_W-1:0] LAST_POS = jrs_pkg::POS_W'(BLOCK_SIZE - 1);

  logic [jrs_pkg::POS_W-1:0]     zero_run_r, zero_run_nxt;
  logic [jrs_pkg::POS_W-1:0]     pos_r, pos_nxt;
  logic [jrs_pkg::COEF_BITS-1:0] raw;
  logic [jrs_pkg::COEF_BITS-1:0] mag;
  logic [jrs_pkg::SIZE_W-1:0]    size;
  logic                          last_eff;
  logic                          acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign raw      = in_data.coefficient;
  assign mag      = raw[jrs_pkg::COEF_BITS-1] ? (~raw + 1'b1) : raw;
  assign last_eff = in_data.block_last || (pos_r == LAST_POS);

  always_comb begin
    size = '0;
    for (int i = 0; i < jrs_pkg::COEF_BITS; i++) begin
      if (mag[i]) begin
        size = jrs_pkg::SIZE_W'(i + 1);
      end
    end
  end

  always_comb begin
    push                = 1'b0;
    push_job.zrl        = '0;
    push_job.run_size   = {{(jrs_pkg::SYM_W-jrs_pkg::SIZE_W){1'b0}}, size};
    push_job.amplitude  = in_data.coefficient;
    push_job.block_done = last_eff;
    zero_run_nxt        = zero_run_r;
    pos_nxt             = pos_r;
    if (acc) begin
      if (pos_r == '0) begin
        push = 1'b1;
      end else if (mag == '0) begin
        if (last_eff) begin
          push                = 1'b1;
          push_job.run_size   = jrs_pkg::SYM_EOB;
          push_job.amplitude  = '0;
          push_job.block_done = 1'b1;
        end else begin
          zero_run_nxt = zero_run_r + 1'b1;
        end
      end else begin
        push              = 1'b1;
        push_job.zrl      = zero_run_r[5:4];
        push_job.run_size = {zero_run_r[3:0], size};
        zero_run_nxt      = '0;
      end
      if (last_eff) begin
        zero_run_nxt = '0;
        pos_nxt      = '0;
      end else begin
        pos_nxt = pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_run_r <= '0;
      pos_r      <= '0;
    end else begin
      zero_run_r <= zero_run_nxt;
      pos_r      <= pos_nxt;
    end
  end

endmodule

/* src/jrs_queue.sv */
// Short job queue between front and back ends.
// Depends on jrs_pkg.
module jrs_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  jrs_pkg::job_t push_job,
  input  logic          pop,
  output logic          full,
  output logic          empty,
  output jrs_pkg::job_t head
);

  jrs_pkg::job_t               mem_r [jrs_pkg::QUEUE_DEPTH];
  logic [jrs_pkg::QPTR_W-1:0]  wp_r, rp_r;
  logic [jrs_pkg::QPTR_W:0]    cnt_r;

  assign full  = (cnt_r == (jrs_pkg::QPTR_W+1)'(jrs_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

/* src/jrs_back.sv */
// Back end: expands each job into ZRL words and its symbol, output register.
// Depends on jrs_pkg.
module jrs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               empty,
  input  jrs_pkg::job_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output jrs_pkg::out_word_t out_data
);

  logic                          out_valid_r;
  jrs_pkg::out_word_t            out_data_r, out_data_nxt;
  logic [jrs_pkg::ZRL_CNT_W-1:0] zcnt_r, zcnt_nxt;
  logic                          load;
  logic                          zrl_step;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign load      = !out_valid_r || !out_stall;
  assign zrl_step  = (zcnt_r != head.zrl);
  assign pop       = load && !empty && !zrl_step;

  always_comb begin
    zcnt_nxt     = zcnt_r;
    out_data_nxt = out_data_r;
    if (load && !empty) begin
      if (zrl_step) begin
        zcnt_nxt                 = zcnt_r + 1'b1;
        out_data_nxt.run_size    = jrs_pkg::SYM_ZRL;
        out_data_nxt.amplitude   = '0;
        out_data_nxt.result_last = 1'b0;
        out_data_nxt.block_done  = 1'b0;
      end else begin
        zcnt_nxt                 = '0;
        out_data_nxt.run_size    = head.run_size;
        out_data_nxt.amplitude   = head.amplitude;
        out_data_nxt.result_last = 1'b1;
        out_data_nxt.block_done  = head.block_done;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      zcnt_r      <= '0;
    end else begin
      zcnt_r <= zcnt_nxt;
      if (load) begin
        out_valid_r <= !empty;
      end
    end
  end

endmodule

/* src/jpeg_run_size_encoder_core.sv */
// Top level of the JPEG zig-zag run/size encoder.
// Depends on jrs_pkg, jrs_front, jrs_queue, jrs_back.
//
//   channel  direction  handshake             word
//   in_      input      in_valid / in_stall   jrs_pkg::in_word_t
//   out_     output     out_valid / out_stall jrs_pkg::out_word_t
//
// One coefficient word per cycle is taken while the job queue has room.
// Each job leaves the output register one word per cycle while out_stall is low:
// up to three ZRL words, set by the back end's ZRL counter, then its symbol.
// Each job passes through the job queue before its first word is registered.
// Synchronous active-low reset clears run, position, queue and output valid.
module jpeg_run_size_encoder_core #(
  parameter int BLOCK_SIZE = jrs_pkg::BLOCK_SIZE
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  jrs_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output jrs_pkg::out_word_t out_data
);

  logic          push, pop, q_full, q_empty;
  jrs_pkg::job_t push_job, head;

  jrs_front #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  jrs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .empty    (q_empty),
    .head     (head)
  );

  jrs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
